>>> src/tps_pkg.sv
package tps_pkg;

    // Register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TOUCH_LEVEL        = 2'd0;
    localparam logic [1:0] REG_LONG_HOLD_MS       = 2'd1;
    localparam logic [1:0] REG_TOGGLE_DEBOUNCE_MS = 2'd2;

    localparam logic [15:0] TOUCH_LEVEL_RST        = 16'd50;
    localparam logic [15:0] LONG_HOLD_MS_RST       = 16'd800;
    localparam logic [15:0] TOGGLE_DEBOUNCE_MS_RST = 16'd400;

    localparam int NUM_PADS = 5;

    // Mode codes
    localparam logic [1:0] MODE_SINGLE = 2'd0;
    localparam logic [1:0] MODE_LOOP   = 2'd1;
    localparam logic [1:0] MODE_RECORD = 2'd2;

    // Event kinds
    localparam logic EVT_MODE = 1'b0;
    localparam logic EVT_HIT  = 1'b1;

    typedef struct packed {
        logic [15:0] touch_level;
        logic [15:0] long_hold_ms;
        logic [15:0] toggle_debounce_ms;
    } cfg_t;

    // One classified scan: optional mode event, then one hit per set mask bit
    typedef struct packed {
        logic                mode_evt;
        logic [1:0]          mode;
        logic [NUM_PADS-1:0] hits;
    } job_t;

endpackage

>>> src/tps_regs.sv
module tps_regs
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tps_pkg::cfg_t       cfg
);

    logic [15:0] thr_reg;
    logic [15:0] thr_next;
    logic [15:0] lp_reg;
    logic [15:0] lp_next;
    logic [15:0] deb_reg;
    logic [15:0] deb_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        thr_next = thr_reg;
        lp_next  = lp_reg;
        deb_next = deb_reg;
        if (wr_en)
        begin
            case (paddr[3:2])
                tps_pkg::REG_TOUCH_LEVEL:        thr_next = pwdata[15:0];
                tps_pkg::REG_LONG_HOLD_MS:       lp_next  = pwdata[15:0];
                tps_pkg::REG_TOGGLE_DEBOUNCE_MS: deb_next = pwdata[15:0];
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= tps_pkg::TOUCH_LEVEL_RST;
            lp_reg  <= tps_pkg::LONG_HOLD_MS_RST;
            deb_reg <= tps_pkg::TOGGLE_DEBOUNCE_MS_RST;
        end
        else
        begin
            thr_reg <= thr_next;
            lp_reg  <= lp_next;
            deb_reg <= deb_next;
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            tps_pkg::REG_TOUCH_LEVEL:        prdata = {16'd0, thr_reg};
            tps_pkg::REG_LONG_HOLD_MS:       prdata = {16'd0, lp_reg};
            tps_pkg::REG_TOGGLE_DEBOUNCE_MS: prdata = {16'd0, deb_reg};
            default:                         prdata = 32'd0;
        endcase
    end

    assign cfg.touch_level        = thr_reg;
    assign cfg.long_hold_ms       = lp_reg;
    assign cfg.toggle_debounce_ms = deb_reg;

endmodule

>>> src/tps_front.sv
module tps_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  tps_pkg::cfg_t       cfg,
    input  logic                scan_valid,
    output logic                scan_ready,
    input  logic [127:0]        scan_data,
    input  logic                q_full,
    output logic                q_push,
    output tps_pkg::job_t       q_job
);

    logic [1:0]                   mode_reg;
    logic [1:0]                   mode_next;
    logic [tps_pkg::NUM_PADS-1:0] pad_was_reg;
    logic [tps_pkg::NUM_PADS-1:0] pad_was_next;
    logic                         mode_was_reg;
    logic                         mode_was_next;
    logic [31:0]                  press_start_reg;
    logic [31:0]                  press_start_next;
    logic                         long_seen_reg;
    logic                         long_seen_next;
    logic [31:0]                  last_toggle_reg;
    logic [31:0]                  last_toggle_next;

    logic [31:0]                  now;
    logic                         touched;
    logic [31:0]                  held_ms;
    logic [31:0]                  since_toggle;
    logic                         long_ok;
    logic                         long_evt;
    logic                         toggle_evt;
    logic [tps_pkg::NUM_PADS-1:0] pad_touched;
    logic [tps_pkg::NUM_PADS-1:0] hits;
    logic                         accept;

    assign now          = scan_data[31:0];
    assign touched      = scan_data[47:32] < cfg.touch_level;
    assign held_ms      = now - press_start_reg;
    assign since_toggle = now - last_toggle_reg;
    assign long_ok      = held_ms >= {16'd0, cfg.long_hold_ms};

    assign long_evt   = touched && mode_was_reg && !long_seen_reg && long_ok;
    assign toggle_evt = !touched && mode_was_reg && !long_seen_reg && !long_ok
                        && (since_toggle > {16'd0, cfg.toggle_debounce_ms});

    always_comb
    begin
        for (int i = 0; i < tps_pkg::NUM_PADS; i++)
        begin
            pad_touched[i] = scan_data[48 + 16*i +: 16] < cfg.touch_level;
        end
    end

    assign hits = pad_touched & ~pad_was_reg;

    assign scan_ready = !q_full;
    assign accept     = scan_valid && scan_ready;

    // Classify and advance the pad state on every accepted scan
    always_comb
    begin
        mode_next        = mode_reg;
        pad_was_next     = pad_was_reg;
        mode_was_next    = mode_was_reg;
        press_start_next = press_start_reg;
        long_seen_next   = long_seen_reg;
        last_toggle_next = last_toggle_reg;
        if (accept)
        begin
            if (touched && !mode_was_reg)
            begin
                press_start_next = now;
                long_seen_next   = 1'b0;
            end
            if (long_evt)
            begin
                long_seen_next = 1'b1;
                mode_next      = tps_pkg::MODE_RECORD;
            end
            if (toggle_evt)
            begin
                mode_next        = (mode_reg == tps_pkg::MODE_SINGLE) ? tps_pkg::MODE_LOOP
                                                                      : tps_pkg::MODE_SINGLE;
                last_toggle_next = now;
            end
            mode_was_next = touched;
            pad_was_next  = pad_touched;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tps_pkg::MODE_SINGLE;
            pad_was_reg     <= '0;
            mode_was_reg    <= 1'b0;
            press_start_reg <= 32'd0;
            long_seen_reg   <= 1'b0;
            last_toggle_reg <= 32'd0;
        end
        else
        begin
            mode_reg        <= mode_next;
            pad_was_reg     <= pad_was_next;
            mode_was_reg    <= mode_was_next;
            press_start_reg <= press_start_next;
            long_seen_reg   <= long_seen_next;
            last_toggle_reg <= last_toggle_next;
        end
    end

    // Drop scans that produce no event; the rest go to the queue
    assign q_job.mode_evt = long_evt || toggle_evt;
    assign q_job.mode     = mode_next;
    assign q_job.hits     = hits;
    assign q_push         = accept && (q_job.mode_evt || (hits != '0));

endmodule

>>> src/tps_queue.sv
module tps_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tps_pkg::job_t       push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output tps_pkg::job_t       head_job
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    tps_pkg::job_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full       = count_reg == FULL_CNT;
    assign head_valid = count_reg != '0;
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

>>> src/tps_back.sv
module tps_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  tps_pkg::job_t       q_job,
    output logic                q_pop,
    output logic                ev_valid,
    input  logic                ev_ready,
    output logic                ev_kind,
    output logic [1:0]          ev_mode,
    output logic [2:0]          ev_pad,
    output logic                ev_last
);

    logic                         pend_valid_reg;
    logic                         pend_valid_next;
    tps_pkg::job_t                pend_reg;
    tps_pkg::job_t                pend_next;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic                         out_kind_reg;
    logic                         out_kind_next;
    logic [1:0]                   out_mode_reg;
    logic [1:0]                   out_mode_next;
    logic [2:0]                   out_pad_reg;
    logic [2:0]                   out_pad_next;
    logic                         out_last_reg;
    logic                         out_last_next;

    logic                         slot_free;
    logic                         emit;
    logic [2:0]                   low_idx;
    logic [tps_pkg::NUM_PADS-1:0] mask_after;
    logic                         cur_kind;
    logic [2:0]                   cur_pad;
    logic                         cur_last;
    logic                         finish;

    // Lowest pending pad
    always_comb
    begin
        low_idx = 3'd0;
        for (int i = tps_pkg::NUM_PADS - 1; i >= 0; i--)
        begin
            if (pend_reg.hits[i])
            begin
                low_idx = 3'(i);
            end
        end
    end

    always_comb
    begin
        if (pend_reg.mode_evt)
        begin
            cur_kind   = tps_pkg::EVT_MODE;
            cur_pad    = 3'd0;
            mask_after = pend_reg.hits;
        end
        else
        begin
            cur_kind   = tps_pkg::EVT_HIT;
            cur_pad    = low_idx;
            mask_after = pend_reg.hits & ~(tps_pkg::NUM_PADS'(1) << low_idx);
        end
        cur_last = mask_after == '0;
    end

    assign slot_free = !out_valid_reg || ev_ready;
    assign emit      = pend_valid_reg && slot_free;
    assign finish    = emit && cur_last;
    assign q_pop     = q_valid && (!pend_valid_reg || finish);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (q_pop)
        begin
            pend_valid_next = 1'b1;
            pend_next       = q_job;
        end
        else if (finish)
        begin
            pend_valid_next = 1'b0;
        end
        else if (emit)
        begin
            pend_next.mode_evt = 1'b0;
            pend_next.hits     = mask_after;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_kind_next  = out_kind_reg;
        out_mode_next  = out_mode_reg;
        out_pad_next   = out_pad_reg;
        out_last_next  = out_last_reg;
        if (slot_free)
        begin
            out_valid_next = emit;
            out_kind_next  = cur_kind;
            out_mode_next  = pend_reg.mode;
            out_pad_next   = cur_pad;
            out_last_next  = cur_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_kind_reg <= out_kind_next;
        out_mode_reg <= out_mode_next;
        out_pad_reg  <= out_pad_next;
        out_last_reg <= out_last_next;
    end

    assign ev_valid = out_valid_reg;
    assign ev_kind  = out_kind_reg;
    assign ev_mode  = out_mode_reg;
    assign ev_pad   = out_pad_reg;
    assign ev_last  = out_last_reg;

endmodule

>>> src/touch_pad_event_scanner.sv
// Touch pad event scanner: turns periodic pad scans into mode and hit events.
// Input stream (s_axis): one transfer per scan carrying the millisecond
// timestamp, the mode pad reading and five instrument pad readings.
// Output stream (m_axis): one transfer per event. tuser gives the kind
// (mode change or pad hit), tdata the mode and pad index, tlast marks the
// final event of a scan. Scans that cause no event produce no transfer.
// Configuration (APB): threshold, long-press time and toggle debounce time at
// byte addresses 0, 4 and 8; writes complete in the access cycle, pready is
// tied high. Write them only while the block is idle.
// Throughput: the front end takes one scan per cycle as long as the job
// queue has room; the back end sends one event per cycle while the
// receiver accepts, set by the single output register; a scan yields one
// to six events. The first event of a scan passes the job queue, the
// pending-job register and the output register before it appears.
// Reset returns registers to 50 / 800 / 400 and clears mode and pad history.
// When the receiver stalls, the output register holds its event, the back
// end waits, the queue fills and s_axis_tready drops.
module touch_pad_event_scanner
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] time_ms, [47:32] mode_reading, [63:48] pad0_reading,
    // [79:64] pad1_reading, [95:80] pad2_reading, [111:96] pad3_reading,
    // [127:112] pad4_reading
    input  logic [127:0] s_axis_tdata,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [1:0] mode_value, [4:2] pad_index, [7:5] zero
    output logic [7:0]   m_axis_tdata,
    // [0] event_kind
    output logic         m_axis_tuser,
    output logic         m_axis_tlast,

    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    tps_pkg::cfg_t cfg;
    tps_pkg::job_t push_job;
    tps_pkg::job_t head_job;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_valid;
    logic [1:0]    ev_mode;
    logic [2:0]    ev_pad;

    // Configuration registers
    tps_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: threshold the readings, track press timing, build one job per scan that causes an event
    tps_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .scan_valid (s_axis_tvalid),
        .scan_ready (s_axis_tready),
        .scan_data  (s_axis_tdata),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_job      (push_job)
    );

    // Decouple scan intake from event output
    tps_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (head_job)
    );

    // Back end: expand each job into events, mode event first, then hits in pad order
    tps_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_job    (head_job),
        .q_pop    (q_pop),
        .ev_valid (m_axis_tvalid),
        .ev_ready (m_axis_tready),
        .ev_kind  (m_axis_tuser),
        .ev_mode  (ev_mode),
        .ev_pad   (ev_pad),
        .ev_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, ev_pad, ev_mode};

endmodule
